@@ sv/ttcw_pkg.sv @@
// ----------------------------------------------------------------------------
// ttcw_pkg: shared definitions for the text terminal cell writer
// Screen geometry, field widths, character codes and the cursor link types.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned SHIFT_LAST = (ROWS - 1) * COLUMNS;

  // Internal widths
  localparam int unsigned MEM_AW = $clog2(CELL_COUNT);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COLX_W = $clog2(COLUMNS + 8);
  localparam int unsigned ROWX_W = $clog2(ROWS + 1);

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned LOC_W   = 11;
  localparam int unsigned CELL_W  = 16;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (LOC_W + CELL_W + 1);

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Character codes
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_LAST  = 8'h7F;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Top -> cursor
  typedef struct packed {
    logic              put;
    logic              home;
    logic [CODE_W-1:0] code;
  } cur_cmd_t;

  // Cursor -> top
  typedef struct packed {
    logic [MEM_AW-1:0] cell_idx;   // current cursor cell
    logic [LOC_W-1:0]  loc;        // current cursor location
    logic [LOC_W-1:0]  put_loc;    // location after a put of code
    logic              put_scroll; // a put of code scrolls
    logic              printable;  // code writes a cell
    logic [ROW_W-1:0]  row;
  } cur_stat_t;

endpackage

`default_nettype wire

@@ sv/ttcw_ram.sv @@
// ----------------------------------------------------------------------------
// ttcw_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/ttcw_cursor.sv @@
// ----------------------------------------------------------------------------
// ttcw_cursor: cursor position and control-code handling
// Holds column and row, works out the position after a put request.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_cursor import ttcw_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cur_cmd_t  cmd_i,
  output cur_stat_t      stat_o
);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COLX_W-1:0] col_x;
  logic [ROWX_W-1:0] row_x;
  logic [COL_W-1:0]  col_n;
  logic [ROW_W-1:0]  row_n;
  logic              printable;
  logic              scroll;

  function automatic logic [MEM_AW-1:0] loc_of(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
    return MEM_AW'(row) * MEM_AW'(COLUMNS) + MEM_AW'(col);
  endfunction

  always_comb begin
    col_x     = COLX_W'(col_q);
    row_x     = ROWX_W'(row_q);
    printable = (cmd_i.code >= CH_SPACE) && (cmd_i.code <= CH_LAST);
    case (cmd_i.code)
      CH_BS: begin
        if (col_x != '0) begin
          col_x = col_x - COLX_W'(1);
        end
      end
      CH_TAB: col_x = (col_x + COLX_W'(8)) & ~COLX_W'(7);
      CH_CR:  col_x = '0;
      CH_LF: begin
        col_x = '0;
        row_x = row_x + ROWX_W'(1);
      end
      default: begin
        if (printable) begin
          col_x = col_x + COLX_W'(1);
        end
      end
    endcase
    // wrap past the last column
    if (col_x >= COLX_W'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + ROWX_W'(1);
    end
    scroll = (row_x >= ROWX_W'(ROWS));
    if (scroll) begin
      row_x = ROWX_W'(ROWS - 1);
    end
    col_n = COL_W'(col_x);
    row_n = ROW_W'(row_x);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.home) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.put) begin
      col_d = col_n;
      row_d = row_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    stat_o.cell_idx   = loc_of(row_q, col_q);
    stat_o.loc        = LOC_W'(stat_o.cell_idx);
    stat_o.put_loc    = LOC_W'(loc_of(row_n, col_n));
    stat_o.put_scroll = scroll;
    stat_o.printable  = printable;
    stat_o.row        = row_q;
  end

endmodule

`default_nettype wire

@@ sv/text_terminal_cell_writer.sv @@
// ----------------------------------------------------------------------------
// text_terminal_cell_writer: character-cell text terminal over a screen RAM
// Put character, clear screen and read cell requests on a stream input; one
// result per request carrying cursor location, read data and a scroll flag.
// ----------------------------------------------------------------------------
// Put without scroll: cell write and result at the accept edge. Read: result
// once the registered RAM read data arrives. Clear and scroll: result after
// the one-cell-per-cycle sweep through the screen RAM and the drain step.
// Throughput: one put or undecoded request per cycle while results are taken;
// a read, clear or scroll holds off requests until it ends. Reset: cursor
// homed, then a sweep blanks the RAM; no request is taken until it ends.
`default_nettype none

module text_terminal_cell_writer import ttcw_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request stream
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [7:0] char_code, [11:8] background color, [15:12] foreground color,
  // [26:16] cell_address, [31:27] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] opcode
  input  wire logic [OP_W-1:0]        s_axis_tuser_i,
  // result stream
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [10:0] cursor_location, [26:11] read_data, [27] scrolled, [31:28] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,  // walk the RAM: blank it or shift it up a row
    ST_DRAIN = 4'b0010,  // last sweep write, then report
    ST_IDLE  = 4'b0100,  // take requests
    ST_READ  = 4'b1000   // RAM read data arrives
  } state_e;

  state_e st_q, st_d;

  // Request fields
  op_e                op;
  logic [CODE_W-1:0]  char_code;
  logic [COLOR_W-1:0] bg_nibble;
  logic [COLOR_W-1:0] fg_nibble;
  logic [ADDR_W-1:0]  cell_address;
  logic               accept;

  assign op           = op_e'(s_axis_tuser_i);
  assign char_code    = s_axis_tdata_i[CODE_W-1:0];
  assign bg_nibble    = s_axis_tdata_i[CODE_W +: COLOR_W];
  assign fg_nibble    = s_axis_tdata_i[CODE_W+COLOR_W +: COLOR_W];
  assign cell_address = s_axis_tdata_i[CODE_W+2*COLOR_W +: ADDR_W];

  // Output register
  logic              out_valid_q;
  logic [LOC_W-1:0]  out_loc_q;
  logic [CELL_W-1:0] out_data_q;
  logic              out_scr_q;

  assign s_axis_tready_o = (st_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Cursor
  cur_cmd_t  cur_cmd;
  cur_stat_t cur_stat;

  assign cur_cmd.put  = accept && (op == OP_PUT);
  assign cur_cmd.home = accept && (op == OP_CLEAR);
  assign cur_cmd.code = char_code;

  ttcw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .stat_o (cur_stat)
  );

  // Sweep bookkeeping. The sweep write stage trails the read by a register:
  // the cell read at cnt+COLUMNS lands at cnt on the next cycle.
  logic [MEM_AW-1:0] cnt_q, cnt_d;
  logic              shift_q, shift_d;    // scroll sweep, else blank sweep
  logic              report_q, report_d;  // give a result when done
  logic              wr_valid_q, wr_valid_d;
  logic [MEM_AW-1:0] wr_addr_q, wr_addr_d;
  logic              wr_ram_q, wr_ram_d;  // copy read data, else blank
  logic              addr_ok_q, addr_ok_d;

  // RAM ports
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [MEM_AW-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic              put_we;

  // Result load
  logic              load;
  logic [LOC_W-1:0]  ld_loc;
  logic [CELL_W-1:0] ld_data;
  logic              ld_scr;

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    report_d   = report_q;
    wr_valid_d = 1'b0;
    wr_addr_d  = cnt_q;
    wr_ram_d   = 1'b0;
    addr_ok_d  = addr_ok_q;
    ram_re     = 1'b0;
    ram_raddr  = MEM_AW'(cell_address);
    put_we     = 1'b0;
    load       = 1'b0;
    ld_loc     = cur_stat.loc;
    ld_data    = '0;
    ld_scr     = 1'b0;

    unique case (st_q)
      ST_SWEEP: begin
        wr_valid_d = 1'b1;
        if (shift_q && (cnt_q < MEM_AW'(SHIFT_LAST))) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q + MEM_AW'(COLUMNS);
          wr_ram_d  = 1'b1;
        end
        if (cnt_q == MEM_AW'(CELL_COUNT - 1)) begin
          st_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + MEM_AW'(1);
        end
      end
      ST_DRAIN: begin
        load   = report_q;
        ld_scr = shift_q;
        st_d   = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_PUT: begin
              put_we = cur_stat.printable;
              if (cur_stat.put_scroll) begin
                st_d     = ST_SWEEP;
                cnt_d    = '0;
                shift_d  = 1'b1;
                report_d = 1'b1;
              end else begin
                load   = 1'b1;
                ld_loc = cur_stat.put_loc;
              end
            end
            OP_CLEAR: begin
              st_d     = ST_SWEEP;
              cnt_d    = '0;
              shift_d  = 1'b0;
              report_d = 1'b1;
            end
            OP_READ: begin
              addr_ok_d = (cell_address < ADDR_W'(CELL_COUNT));
              ram_re    = addr_ok_d;
              st_d      = ST_READ;
            end
            default: begin
              // unused opcode: no state change
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load    = 1'b1;
        ld_data = addr_ok_q ? ram_rdata : '0;
        st_d    = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Sweep writes and put writes never overlap: puts are taken in idle only.
  assign ram_we    = wr_valid_q || put_we;
  assign ram_waddr = wr_valid_q ? wr_addr_q : cur_stat.cell_idx;
  assign ram_wdata = wr_valid_q ? (wr_ram_q ? ram_rdata : BLANK_CELL)
                                : {bg_nibble, fg_nibble, char_code};

  ttcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers; reset starts the blanking sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_SWEEP;
      cnt_q       <= '0;
      shift_q     <= 1'b0;
      report_q    <= 1'b0;
      wr_valid_q  <= 1'b0;
      addr_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      report_q   <= report_d;
      wr_valid_q <= wr_valid_d;
      addr_ok_q  <= addr_ok_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    wr_ram_q  <= wr_ram_d;
    if (load) begin
      out_loc_q  <= ld_loc;
      out_data_q <= ld_data;
      out_scr_q  <= ld_scr;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_scr_q, out_data_q, out_loc_q};

  // Assertions
  a_sweep_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_q |-> (st_q == ST_SWEEP || st_q == ST_DRAIN))
    else $error("sweep write outside a sweep");

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_READ) |-> !out_valid_q)
    else $error("read data arrives while a result is still held");

  a_scroll_bottom_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scr_q) |-> (cur_stat.row == ROW_W'(ROWS - 1)))
    else $error("scroll reported with cursor off the bottom row");

  a_sweep_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SWEEP) |-> (cnt_q < MEM_AW'(CELL_COUNT)))
    else $error("sweep counter out of range");

endmodule

`default_nettype wire

@@ dv/tb_text_terminal_cell_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_terminal_cell_writer: self-checking bench for the text terminal
// A short hand-checked table, then random put, clear, read and unused-opcode
// traffic; results checked against goldens or a shadow screen and cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_terminal_cell_writer;
  import ttcw_pkg::*;

  // opcode 3 is not decoded by the block; it must leave everything alone
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned RANDOM_REQUESTS = 1825;
  // settle time once the last result is in: one full store sweep plus margin
  localparam int unsigned DRAIN_CYCLES    = CELL_COUNT + 10;

  typedef struct packed {
    logic [LOC_W-1:0]  loc;
    logic [CELL_W-1:0] rd_word;
    logic              scrolled;
  } term_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] back;
    logic [COLOR_W-1:0] fore;
    logic [ADDR_W-1:0]  addr;
    logic               has_golden;  // golden below is typed in by hand
    term_result_t       golden;
  } term_request_t;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [OP_W-1:0]        s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  text_terminal_cell_writer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow terminal: screen copy, cursor and the results still owed
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  int unsigned       cursor_col;
  int unsigned       cursor_row;
  term_result_t      awaited_results [$];
  int unsigned       mismatches  = 0;
  bit                steady_flow = 1'b0;  // stretch with no idling on either side

  function automatic int unsigned idle_cycles();
    return steady_flow ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = BLANK_CELL;
  endfunction

  // Applies one request to the shadow terminal and returns the result it owes.
  function automatic term_result_t apply_request(input term_request_t req);
    term_result_t res;
    int unsigned  col;
    int unsigned  row;
    res = '0;
    col = cursor_col;
    row = cursor_row;
    case (req.op)
      OP_PUT: begin
        if (req.code == CH_BS) begin
          if (col != 0) col--;
        end else if (req.code == CH_TAB) begin
          col = (col + 8) & ~32'd7;
        end else if (req.code == CH_CR) begin
          col = 0;
        end else if (req.code == CH_LF) begin
          col = 0;
          row++;
        end else if (req.code >= CH_SPACE && req.code <= CH_LAST) begin
          // attribute byte is background nibble over foreground nibble
          shadow_screen[row * COLUMNS + col] = {req.back, req.fore, req.code};
          col++;
        end
        // everything else (other control codes, 128..255) is dropped
        if (col >= COLUMNS) begin
          col = 0;
          row++;
        end
        if (row >= ROWS) begin
          for (int i = 0; i < SHIFT_LAST; i++)
            shadow_screen[i] = shadow_screen[i + COLUMNS];
          for (int i = SHIFT_LAST; i < CELL_COUNT; i++)
            shadow_screen[i] = BLANK_CELL;
          row          = ROWS - 1;
          res.scrolled = 1'b1;
        end
        cursor_col = col;
        cursor_row = row;
      end
      OP_CLEAR: begin
        blank_screen();
        cursor_col = 0;
        cursor_row = 0;
      end
      OP_READ: begin
        // reads past the end of the store return zero
        if (req.addr < CELL_COUNT) res.rd_word = shadow_screen[req.addr];
      end
      default: ;
    endcase
    res.loc = LOC_W'(cursor_row * COLUMNS + cursor_col);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Entered and left at a rising edge. tvalid is only lowered when a gap is
  // drawn, so back-to-back requests keep it high without a glitch.
  task automatic send_request(input term_request_t req);
    term_result_t predicted;
    int unsigned  gap;
    gap = idle_cycles();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req.op;
    s_axis_tdata_i  <= {5'b0, req.addr, req.fore, req.back, req.code};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_request(req);
    awaited_results.push_back(req.has_golden ? req.golden : predicted);
  endtask

  function automatic logic [CODE_W-1:0] ignored_code();
    logic [CODE_W-1:0] code;
    if ($urandom_range(0, 1) == 0) return CODE_W'($urandom_range(128, 255));
    do code = CODE_W'($urandom_range(0, 31));
    while (code == CH_BS || code == CH_TAB || code == CH_LF || code == CH_CR);
    return code;
  endfunction

  // Mostly printable text with line breaks sprinkled in, so the cursor walks
  // to the bottom row and scrolls; clears are rare since each sweeps the RAM.
  function automatic term_request_t random_request();
    term_request_t req;
    int unsigned   pick;
    int unsigned   loc;
    req      = '0;
    req.code = CODE_W'($urandom_range(0, 255));
    req.back = COLOR_W'($urandom_range(0, 15));
    req.fore = COLOR_W'($urandom_range(0, 15));
    req.addr = ADDR_W'($urandom_range(0, 2047));
    req.op   = OP_PUT;
    pick     = $urandom_range(0, 999);
    if (pick < 5) begin
      req.op = OP_CLEAR;
    end else if (pick < 25) begin
      req.op = OP_UNUSED;
    end else if (pick < 205) begin
      req.op = OP_READ;
      loc    = cursor_row * COLUMNS + cursor_col;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: req.addr = ADDR_W'(loc - $urandom_range(0, (loc < 160) ? loc : 160));
        4:          req.addr = ADDR_W'($urandom_range(CELL_COUNT, 2047));
        default:    ;
      endcase
    end else if (pick < 305) begin
      req.code = CH_LF;
    end else if (pick < 335) begin
      req.code = CH_CR;
    end else if (pick < 375) begin
      req.code = CH_BS;
    end else if (pick < 425) begin
      req.code = CH_TAB;
    end else if (pick < 485) begin
      req.code = ignored_code();
    end else begin
      req.code = CODE_W'($urandom_range(CH_SPACE, CH_LAST));
    end
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field compare
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    term_result_t seen;
    term_result_t want;
    int unsigned  wait_cycles;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= 0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      seen.loc      = m_axis_tdata_o[10:0];
      seen.rd_word  = m_axis_tdata_o[26:11];
      seen.scrolled = m_axis_tdata_o[27];
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no request pending: loc %0d data %h scrolled %b",
                 $time, seen.loc, seen.rd_word, seen.scrolled);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (seen.loc !== want.loc) begin
          $display("%0t: cursor_location expected %0d got %0d", $time, want.loc, seen.loc);
          mismatches++;
        end
        if (seen.rd_word !== want.rd_word) begin
          $display("%0t: read_data expected %h got %h", $time, want.rd_word, seen.rd_word);
          mismatches++;
        end
        if (seen.scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %b got %b", $time, want.scrolled, seen.scrolled);
          mismatches++;
        end
      end
      wait_cycles = idle_cycles();
      stall_left      <= wait_cycles;
      m_axis_tready_i <= (wait_cycles == 0);
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= (stall_left == 1);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Directed requests; golden results only where they are obvious
  // --------------------------------------------------------------------------
  term_request_t directed_steps [0:24] = '{
    // untouched store after reset, both ends and past the end
    '{OP_READ,   8'h00,  4'h0, 4'h0, 11'd0,    1'b1, '{11'd0,  16'h0F20, 1'b0}},
    '{OP_READ,   8'h00,  4'h0, 4'h0, 11'd1999, 1'b1, '{11'd0,  16'h0F20, 1'b0}},
    '{OP_READ,   8'h00,  4'h0, 4'h0, 11'd2047, 1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{OP_READ,   8'h00,  4'h0, 4'h0, 11'd2000, 1'b1, '{11'd0,  16'h0000, 1'b0}},
    // undecoded opcode is a no-op
    '{OP_UNUSED, 8'h41,  4'hF, 4'hF, 11'd0,    1'b1, '{11'd0,  16'h0000, 1'b0}},
    // printable range ends and colour extremes
    '{OP_PUT,    8'h41,  4'h0, 4'h0, 11'd0,    1'b1, '{11'd1,  16'h0000, 1'b0}},
    '{OP_PUT,    CH_LAST, 4'hF, 4'hF, 11'd0,   1'b1, '{11'd2,  16'h0000, 1'b0}},
    '{OP_PUT,    CH_SPACE, 4'hA, 4'h5, 11'd0,  1'b1, '{11'd3,  16'h0000, 1'b0}},
    '{OP_READ,   8'h00,  4'h0, 4'h0, 11'd0,    1'b1, '{11'd3,  16'h0041, 1'b0}},
    '{OP_READ,   8'h00,  4'h0, 4'h0, 11'd1,    1'b1, '{11'd3,  16'hFF7F, 1'b0}},
    // control codes; backspace at column 0 stays put
    '{OP_PUT,    CH_BS,  4'h0, 4'h0, 11'd0,    1'b1, '{11'd2,  16'h0000, 1'b0}},
    '{OP_PUT,    CH_TAB, 4'h0, 4'h0, 11'd0,    1'b1, '{11'd8,  16'h0000, 1'b0}},
    '{OP_PUT,    CH_TAB, 4'h0, 4'h0, 11'd0,    1'b1, '{11'd16, 16'h0000, 1'b0}},
    '{OP_PUT,    CH_CR,  4'h0, 4'h0, 11'd0,    1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{OP_PUT,    CH_BS,  4'h0, 4'h0, 11'd0,    1'b1, '{11'd0,  16'h0000, 1'b0}},
    // codes that are dropped, low control and high half
    '{OP_PUT,    8'h00,  4'hF, 4'hF, 11'd0,    1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{OP_PUT,    8'h1F,  4'hF, 4'hF, 11'd0,    1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{OP_PUT,    8'h80,  4'hF, 4'hF, 11'd0,    1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{OP_PUT,    8'hFF,  4'hF, 4'hF, 11'd2047, 1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{OP_PUT,    CH_LF,  4'h0, 4'h0, 11'd0,    1'b1, '{11'd80, 16'h0000, 1'b0}},
    '{OP_PUT,    8'h7E,  4'h3, 4'hC, 11'd0,    1'b0, '0},
    '{OP_READ,   8'hFF,  4'hF, 4'hF, 11'd80,   1'b0, '0},
    // clear blanks the store and homes the cursor
    '{OP_CLEAR,  8'hFF,  4'hF, 4'hF, 11'd2047, 1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{OP_READ,   8'h00,  4'h0, 4'h0, 11'd80,   1'b1, '{11'd0,  16'h0F20, 1'b0}},
    '{OP_READ,   8'h00,  4'h0, 4'h0, 11'd2,    1'b1, '{11'd0,  16'h0F20, 1'b0}}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    blank_screen();
    cursor_col = 0;
    cursor_row = 0;

    // one reset at the start; the block then sweeps its RAM with tready low
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) send_request(directed_steps[i]);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 128 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_request(random_request());
    end
    s_axis_tvalid_i <= 1'b0;
    steady_flow = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_text_terminal_cell_writer: done, clean");
    end else begin
      $display("tb_text_terminal_cell_writer: done, errors");
    end
    $finish;
  end

  // Hard stop, far beyond a run where every request costs a full RAM sweep
  // plus the longest gap and stall on both sides.
  initial begin
    #250_000_000;
    $display("tb_text_terminal_cell_writer: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
